@@ rtl/corexy_move_step_command_gen_top_assert.svh @@
// ----------------------------------------------------------------------------
// corexy move step command generator assertion macros
// concurrent checks that disappear when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef COREXY_MOVE_STEP_COMMAND_GEN_TOP_ASSERT_SVH
`define COREXY_MOVE_STEP_COMMAND_GEN_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent holds in the same cycle as the antecedent
`define CXY_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cxy assertion failed");
// consequent holds in the cycle after the antecedent
`define CXY_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cxy assertion failed");
`else
`define CXY_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CXY_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cxy_pkg.sv @@
// ----------------------------------------------------------------------------
// cxy_pkg
// widths, constants and types shared by the corexy step command generator
// ----------------------------------------------------------------------------
`default_nettype none

package cxy_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MIN_INTERVAL_US = 10;
   localparam int US_PER_S        = 1000000;

   // field widths
   localparam int D_W     = 27;
   localparam int RATE_W  = 20;
   localparam int SPEED_W = 26;
   localparam int SPM_W   = 26;
   localparam int CHAN_W  = 4;
   localparam int IV_W    = 32;
   localparam int CNT_W   = 16;

   // derived datapath widths
   localparam int SQ_W       = 2 * D_W;
   localparam int ROOT_W     = D_W;
   localparam int DA_W       = D_W + 1;
   localparam int AX_PROD_W  = DA_W + SPM_W;
   localparam int AX_STEP_W  = AX_PROD_W - 2 * FRAC_BITS;
   localparam int US_W       = 20;
   localparam int NUM_W      = ROOT_W + US_W;
   localparam int EXT_PROD_W = RATE_W + ROOT_W;
   localparam int EXT_W      = EXT_PROD_W - FRAC_BITS;
   localparam int E_PROD_W   = EXT_W + SPM_W;
   localparam int E_STEP_W   = E_PROD_W - 2 * FRAC_BITS;
   localparam int STEP_W     = (AX_STEP_W > E_STEP_W) ? AX_STEP_W : E_STEP_W;
   localparam int DEN_W      = SPEED_W + STEP_W;

   // squared distance below this means the move is shorter than 0.001 mm
   localparam logic [63:0] MIN_SUMSQ_64 =
      ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;
   localparam logic [SQ_W-1:0] MIN_SUMSQ = MIN_SUMSQ_64[SQ_W-1:0];

   // pipelined square root and divider
   localparam int SQRT_PER_STAGE = 3;
   localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
   localparam int DIV_PER_STAGE  = 2;
   localparam int DIV_STAGES     = IV_W / DIV_PER_STAGE;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_XY_SPM = 2'd0,
      REG_E_SPM  = 2'd1,
      REG_CHAN_A = 2'd2,
      REG_CHAN_B = 2'd3
   } reg_addr_type;

   localparam logic [SPM_W-1:0]  XY_SPM_RESET = 26'd5242880;
   localparam logic [SPM_W-1:0]  E_SPM_RESET  = 26'd6094848;
   localparam logic [CHAN_W-1:0] CHAN_A_RESET = 4'd0;
   localparam logic [CHAN_W-1:0] CHAN_B_RESET = 4'd1;

   typedef struct packed {
      logic                too_short;
      logic [STEP_W-1:0]   a_steps;
      logic [STEP_W-1:0]   b_steps;
      logic                dir_a;
      logic                dir_b;
      logic [RATE_W-1:0]   erate;
      logic [SPEED_W-1:0]  speed;
      logic [CHAN_W-1:0]   echan;
   } item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic              dir;
      logic [CNT_W-1:0]  count;
      logic              last;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/cxy_div.sv @@
// ----------------------------------------------------------------------------
// cxy_div
// pipelined restoring divider for the step interval, saturating and floored
// ----------------------------------------------------------------------------
`default_nettype none

module cxy_div
   import cxy_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire cmd_type          in_cmd,
   output logic                  out_valid,
   output logic [IV_W-1:0]       out_interval,
   output cmd_type               out_cmd
);

   logic             v_ff   [DIV_STAGES+1];
   logic [DEN_W-1:0] rem_ff [DIV_STAGES+1];
   logic [IV_W-1:0]  low_ff [DIV_STAGES+1];
   logic [IV_W-1:0]  q_ff   [DIV_STAGES+1];
   logic [DEN_W-1:0] den_ff [DIV_STAGES+1];
   logic             ovf_ff [DIV_STAGES+1];
   cmd_type          cmd_ff [DIV_STAGES+1];

   logic [DEN_W-1:0] rem_in [DIV_STAGES];
   logic [IV_W-1:0]  low_in [DIV_STAGES];
   logic [IV_W-1:0]  q_in   [DIV_STAGES];

   logic             out_valid_ff;
   logic [IV_W-1:0]  out_interval_ff;
   cmd_type          out_cmd_ff;
   logic [IV_W-1:0]  interval_in;
   logic [DEN_W-1:0] num_hi;

   assign num_hi = DEN_W'(in_num[NUM_W-1:IV_W]);

   always_comb begin
      logic [DEN_W:0]   t;
      logic [DEN_W-1:0] rem;
      logic [IV_W-1:0]  low;
      logic [IV_W-1:0]  q;
      t = '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem = rem_ff[s];
         low = low_ff[s];
         q   = q_ff[s];
         for (int k = 0; k < DIV_PER_STAGE; k++) begin
            t   = {rem, low[IV_W-1]};
            low = low << 1;
            if (t >= {1'b0, den_ff[s]}) begin
               t = t - {1'b0, den_ff[s]};
               q = {q[IV_W-2:0], 1'b1};
            end else begin
               q = {q[IV_W-2:0], 1'b0};
            end
            rem = t[DEN_W-1:0];
         end
         rem_in[s] = rem;
         low_in[s] = low;
         q_in[s]   = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 0; s < DIV_STAGES; s++) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
   end

   // quotient above 32 bits (and zero speed) shows up as high part >= divisor
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num_hi;
         low_ff[0] <= in_num[IV_W-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= in_den;
         ovf_ff[0] <= (num_hi >= in_den);
         cmd_ff[0] <= in_cmd;
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s+1] <= rem_in[s];
            low_ff[s+1] <= low_in[s];
            q_ff[s+1]   <= q_in[s];
            den_ff[s+1] <= den_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
            cmd_ff[s+1] <= cmd_ff[s];
         end
      end
   end

   always_comb begin
      if (ovf_ff[DIV_STAGES]) begin
         interval_in = '1;
      end else if (q_ff[DIV_STAGES] < IV_W'(MIN_INTERVAL_US)) begin
         interval_in = IV_W'(MIN_INTERVAL_US);
      end else begin
         interval_in = q_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_interval_ff <= interval_in;
         out_cmd_ff      <= cmd_ff[DIV_STAGES];
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_interval = out_interval_ff;
   assign out_cmd      = out_cmd_ff;

endmodule

`default_nettype wire

@@ rtl/corexy_move_step_command_gen_top.sv @@
// a move passes the input, square, root, extrusion, expander, divisor and divider registers
// throughput: one command per cycle unless the output stalls; a move holds the
//   input until the expander has at most its last command left
// the pipeline freezes while a result waits; the front also waits for the expander
// reset clears all valid bits and the expander and loads register defaults
`default_nettype none
`include "corexy_move_step_command_gen_top_assert.svh"

// ----------------------------------------------------------------------------
// corexy_move_step_command_gen_top
// corexy move to motor step commands: distance, transform, steps, intervals
// ----------------------------------------------------------------------------
module corexy_move_step_command_gen_top
   import cxy_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // move input
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [D_W-1:0]  req_delta_x,
   input  wire logic signed [D_W-1:0]  req_delta_y,
   input  wire logic [RATE_W-1:0]      req_extrude_rate,
   input  wire logic [SPEED_W-1:0]     req_feed_speed,
   input  wire logic [CHAN_W-1:0]      req_extruder_id,
   // step commands
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [CHAN_W-1:0]           rsp_motor_channel,
   output logic                        rsp_direction,
   output logic [IV_W-1:0]             rsp_interval_us,
   output logic [CNT_W-1:0]            rsp_step_count,
   output logic                        rsp_last_command,
   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int AX_A = 0;
   localparam int AX_B = 1;
   localparam int AX_E = 2;

   // configuration
   logic [SPM_W-1:0]  xy_spm_ff;
   logic [SPM_W-1:0]  e_spm_ff;
   logic [CHAN_W-1:0] chan_a_ff;
   logic [CHAN_W-1:0] chan_b_ff;
   reg_addr_type      csr_idx;

   assign csr_idx    = reg_addr_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xy_spm_ff <= XY_SPM_RESET;
         e_spm_ff  <= E_SPM_RESET;
         chan_a_ff <= CHAN_A_RESET;
         chan_b_ff <= CHAN_B_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            REG_XY_SPM: xy_spm_ff <= csr_pwdata[SPM_W-1:0];
            REG_E_SPM:  e_spm_ff  <= csr_pwdata[SPM_W-1:0];
            REG_CHAN_A: chan_a_ff <= csr_pwdata[CHAN_W-1:0];
            REG_CHAN_B: chan_b_ff <= csr_pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_XY_SPM: csr_prdata = CSR_DATA_W'(xy_spm_ff);
         REG_E_SPM:  csr_prdata = CSR_DATA_W'(e_spm_ff);
         REG_CHAN_A: csr_prdata = CSR_DATA_W'(chan_a_ff);
         REG_CHAN_B: csr_prdata = CSR_DATA_W'(chan_b_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic adv_b;
   logic adv_f;
   logic xm_free;

   // stage 1: input registers
   logic               st1_v_ff;
   logic [D_W-1:0]     st1_dx_ff;
   logic [D_W-1:0]     st1_dy_ff;
   logic [RATE_W-1:0]  st1_erate_ff;
   logic [SPEED_W-1:0] st1_speed_ff;
   logic [CHAN_W-1:0]  st1_echan_ff;

   // stage 2: squares and corexy transform
   logic               st2_v_ff;
   logic [SQ_W-1:0]    st2_sqx_ff;
   logic [SQ_W-1:0]    st2_sqy_ff;
   logic [DA_W-1:0]    st2_da_ff;
   logic [DA_W-1:0]    st2_db_ff;
   logic [RATE_W-1:0]  st2_erate_ff;
   logic [SPEED_W-1:0] st2_speed_ff;
   logic [CHAN_W-1:0]  st2_echan_ff;

   logic [D_W-1:0]     adx;
   logic [D_W-1:0]     ady;
   logic [DA_W-1:0]    da_in;
   logic [DA_W-1:0]    db_in;

   assign adx   = st1_dx_ff[D_W-1] ? (~st1_dx_ff + 1'b1) : st1_dx_ff;
   assign ady   = st1_dy_ff[D_W-1] ? (~st1_dy_ff + 1'b1) : st1_dy_ff;
   assign da_in = {st1_dx_ff[D_W-1], st1_dx_ff} + {st1_dy_ff[D_W-1], st1_dy_ff};
   assign db_in = {st1_dx_ff[D_W-1], st1_dx_ff} - {st1_dy_ff[D_W-1], st1_dy_ff};

   // square root stages, index 0 holds the sum of squares
   logic              sq_v_ff    [SQRT_STAGES+1];
   logic [SQ_W-1:0]   sq_rem_ff  [SQRT_STAGES+1];
   logic [ROOT_W-1:0] sq_root_ff [SQRT_STAGES+1];
   item_type          sq_item_ff [SQRT_STAGES+1];
   logic [SQ_W-1:0]   sq_rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] sq_root_in [SQRT_STAGES];

   logic [SQ_W-1:0]      sum_in;
   logic [DA_W-1:0]      ada;
   logic [DA_W-1:0]      adb;
   logic [AX_PROD_W-1:0] a_prod;
   logic [AX_PROD_W-1:0] b_prod;
   item_type             item_in;

   assign sum_in = st2_sqx_ff + st2_sqy_ff;
   assign ada    = st2_da_ff[DA_W-1] ? (~st2_da_ff + 1'b1) : st2_da_ff;
   assign adb    = st2_db_ff[DA_W-1] ? (~st2_db_ff + 1'b1) : st2_db_ff;
   assign a_prod = AX_PROD_W'(ada) * AX_PROD_W'(xy_spm_ff);
   assign b_prod = AX_PROD_W'(adb) * AX_PROD_W'(xy_spm_ff);

   always_comb begin
      item_in.too_short = (sum_in < MIN_SUMSQ);
      item_in.a_steps   = STEP_W'(a_prod[AX_PROD_W-1:2*FRAC_BITS]);
      item_in.b_steps   = STEP_W'(b_prod[AX_PROD_W-1:2*FRAC_BITS]);
      item_in.dir_a     = st2_da_ff[DA_W-1];
      item_in.dir_b     = st2_db_ff[DA_W-1];
      item_in.erate     = st2_erate_ff;
      item_in.speed     = st2_speed_ff;
      item_in.echan     = st2_echan_ff;
   end

   // digit by digit root, rem keeps value minus root squared
   always_comb begin
      logic [SQ_W-1:0]   rem;
      logic [SQ_W-1:0]   trial;
      logic [ROOT_W-1:0] root;
      int                i;
      trial = '0;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         rem  = sq_rem_ff[s];
         root = sq_root_ff[s];
         for (int k = 0; k < SQRT_PER_STAGE; k++) begin
            i = ROOT_W - 1 - s * SQRT_PER_STAGE - k;
            if (i >= 0) begin
               trial = (SQ_W'(root) << (i + 1)) + (SQ_W'(1) << (2 * i));
               if (rem >= trial) begin
                  rem  = rem - trial;
                  root = root | (ROOT_W'(1) << i);
               end
            end
         end
         sq_rem_in[s]  = rem;
         sq_root_in[s] = root;
      end
   end

   // extrusion stage 1
   logic                  e1_v_ff;
   logic [ROOT_W-1:0]     e1_dist;
   logic [NUM_W-1:0]      e1_num_ff;
   logic [EXT_W-1:0]      e1_ext_ff;
   item_type              e1_item_ff;
   logic [EXT_PROD_W-1:0] ext_prod;

   assign e1_dist  = sq_root_ff[SQRT_STAGES];
   assign ext_prod = EXT_PROD_W'(sq_item_ff[SQRT_STAGES].erate) * EXT_PROD_W'(e1_dist);

   // extrusion stage 2
   logic                e2_v_ff;
   logic [NUM_W-1:0]    e2_num_ff;
   logic [STEP_W-1:0]   e2_esteps_ff;
   item_type            e2_item_ff;
   logic [E_PROD_W-1:0] e_prod;
   logic [2:0]          e2_mask;

   assign e_prod = E_PROD_W'(e1_ext_ff) * E_PROD_W'(e_spm_ff);

   always_comb begin
      e2_mask       = '0;
      e2_mask[AX_A] = (e2_item_ff.a_steps != '0);
      e2_mask[AX_B] = (e2_item_ff.b_steps != '0);
      e2_mask[AX_E] = (e2_esteps_ff != '0);
      if (!e2_v_ff || e2_item_ff.too_short) begin
         e2_mask = '0;
      end
   end

   // expander: one command per cycle from the pending axis mask, unless the output stalls
   logic [2:0]        xm_mask_ff;
   logic [NUM_W-1:0]  xm_num_ff;
   logic [STEP_W-1:0] xm_esteps_ff;
   item_type          xm_item_ff;
   logic [2:0]        xm_rest;
   logic [STEP_W-1:0] xm_steps;
   cmd_type           xm_cmd;

   assign xm_rest = xm_mask_ff & (xm_mask_ff - 3'd1);
   assign xm_free = (xm_rest == '0);

   always_comb begin
      if (xm_mask_ff[AX_A]) begin
         xm_cmd.chan = chan_a_ff;
         xm_cmd.dir  = xm_item_ff.dir_a;
         xm_steps    = xm_item_ff.a_steps;
      end else if (xm_mask_ff[AX_B]) begin
         xm_cmd.chan = chan_b_ff;
         xm_cmd.dir  = xm_item_ff.dir_b;
         xm_steps    = xm_item_ff.b_steps;
      end else begin
         xm_cmd.chan = xm_item_ff.echan;
         xm_cmd.dir  = 1'b0;
         xm_steps    = xm_esteps_ff;
      end
      xm_cmd.count = (xm_steps[STEP_W-1:CNT_W] != '0) ? '1 : xm_steps[CNT_W-1:0];
      xm_cmd.last  = xm_free;
   end

   // divisor stage
   logic             d0_v_ff;
   logic [NUM_W-1:0] d0_num_ff;
   logic [DEN_W-1:0] d0_den_ff;
   cmd_type          d0_cmd_ff;

   logic             div_v;
   logic [IV_W-1:0]  div_interval;
   cmd_type          div_cmd;

   assign adv_b     = !div_v || rsp_ready;
   assign adv_f     = adv_b && xm_free;
   assign req_ready = adv_f;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff <= 1'b0;
         st2_v_ff <= 1'b0;
         for (int s = 0; s <= SQRT_STAGES; s++) begin
            sq_v_ff[s] <= 1'b0;
         end
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
      end else if (adv_f) begin
         st1_v_ff   <= req_valid;
         st2_v_ff   <= st1_v_ff;
         sq_v_ff[0] <= st2_v_ff;
         for (int s = 0; s < SQRT_STAGES; s++) begin
            sq_v_ff[s+1] <= sq_v_ff[s];
         end
         e1_v_ff <= sq_v_ff[SQRT_STAGES];
         e2_v_ff <= e1_v_ff;
      end
   end

   // front payload
   always_ff @(posedge clock) begin
      if (adv_f) begin
         st1_dx_ff    <= req_delta_x;
         st1_dy_ff    <= req_delta_y;
         st1_erate_ff <= req_extrude_rate;
         st1_speed_ff <= req_feed_speed;
         st1_echan_ff <= req_extruder_id;

         st2_sqx_ff   <= SQ_W'(adx) * SQ_W'(adx);
         st2_sqy_ff   <= SQ_W'(ady) * SQ_W'(ady);
         st2_da_ff    <= da_in;
         st2_db_ff    <= db_in;
         st2_erate_ff <= st1_erate_ff;
         st2_speed_ff <= st1_speed_ff;
         st2_echan_ff <= st1_echan_ff;

         sq_rem_ff[0]  <= sum_in;
         sq_root_ff[0] <= '0;
         sq_item_ff[0] <= item_in;
         for (int s = 0; s < SQRT_STAGES; s++) begin
            sq_rem_ff[s+1]  <= sq_rem_in[s];
            sq_root_ff[s+1] <= sq_root_in[s];
            sq_item_ff[s+1] <= sq_item_ff[s];
         end

         e1_num_ff  <= NUM_W'(e1_dist) * NUM_W'(US_PER_S);
         e1_ext_ff  <= ext_prod[EXT_PROD_W-1:FRAC_BITS];
         e1_item_ff <= sq_item_ff[SQRT_STAGES];

         e2_num_ff    <= e1_num_ff;
         e2_esteps_ff <= STEP_W'(e_prod[E_PROD_W-1:2*FRAC_BITS]);
         e2_item_ff   <= e1_item_ff;

         xm_num_ff    <= e2_num_ff;
         xm_esteps_ff <= e2_esteps_ff;
         xm_item_ff   <= e2_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xm_mask_ff <= '0;
      end else if (adv_b) begin
         if (xm_free) begin
            xm_mask_ff <= e2_mask;
         end else begin
            xm_mask_ff <= xm_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_v_ff <= 1'b0;
      end else if (adv_b) begin
         d0_v_ff <= (xm_mask_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         d0_num_ff <= xm_num_ff;
         d0_den_ff <= DEN_W'(xm_item_ff.speed) * DEN_W'(xm_steps);
         d0_cmd_ff <= xm_cmd;
      end
   end

   cxy_div u_div (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv_b),
      .in_valid     (d0_v_ff),
      .in_num       (d0_num_ff),
      .in_den       (d0_den_ff),
      .in_cmd       (d0_cmd_ff),
      .out_valid    (div_v),
      .out_interval (div_interval),
      .out_cmd      (div_cmd)
   );

   assign rsp_valid         = div_v;
   assign rsp_motor_channel = div_cmd.chan;
   assign rsp_direction     = div_cmd.dir;
   assign rsp_interval_us   = div_interval;
   assign rsp_step_count    = div_cmd.count;
   assign rsp_last_command  = div_cmd.last;

   `CXY_ASSERT_SAME(a_stall_blocks_input, clock, reset,
      rsp_valid && !rsp_ready, !req_ready)
   `CXY_ASSERT_SAME(a_result_in_range, clock, reset,
      rsp_valid, (rsp_interval_us >= IV_W'(MIN_INTERVAL_US)) && (rsp_step_count != '0))
   `CXY_ASSERT_SAME(a_input_only_when_expander_free, clock, reset,
      req_ready, $countones(xm_mask_ff) <= 1)
   `CXY_ASSERT_NEXT(a_expander_drops_one, clock, reset,
      adv_b && !xm_free, $countones(xm_mask_ff) == $countones($past(xm_mask_ff)) - 1)

endmodule

`default_nettype wire
